FILE: rtl/bre_pkg.sv
// ----------------------------------------------------------------------------
// bre_pkg: shared types and constants of the byte-run line encoder
// Record limits, state machine codes and the command and status bundles that
// join the controller, the datapath and the output packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bre_pkg;

  localparam int unsigned MAX_RECORD = 128;
  localparam int unsigned MIN_RUN    = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FILL_W     = 3;
  localparam int unsigned LA_W       = 2 * BYTE_W;
  localparam int unsigned LIT_AW     = $clog2(MAX_RECORD);
  localparam int unsigned CNT_W      = $clog2(MAX_RECORD + 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DECIDE   = 8'b0000_0010,
    ST_POST     = 8'b0000_0100,
    ST_RUN_HDR  = 8'b0000_1000,
    ST_RUN_VAL  = 8'b0001_0000,
    ST_LIT_HDR  = 8'b0010_0000,
    ST_LIT_DATA = 8'b0100_0000,
    ST_END      = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RUN_INC,
    OP_RUN_BREAK,
    OP_RUN_START,
    OP_LIT_SHIFT,
    OP_LA_APPEND,
    OP_LAST_LIT
  } dp_op_e;

  typedef enum logic [2:0] {
    PUT_NONE,
    PUT_RUN_HDR,
    PUT_RUN_VAL,
    PUT_LIT_HDR,
    PUT_LIT_DATA
  } put_sel_e;

  typedef struct packed {
    logic     accept;
    dp_op_e   op;
    put_sel_e put;
    logic     step_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_run;
    logic run_match;
    logic la_full;
    logic triple;
    logic la_empty;
    logic lit_empty;
    logic lit_fill_next;
    logic run_full;
    logic line_last;
    logic put_ready;
    logic out_free;
    logic lit_last;
  } dp_status_t;

  typedef struct packed {
    logic              put;
    logic [BYTE_W-1:0] data;
    logic              step_end;
    logic              line_last;
  } pack_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bre_ram.sv
// ----------------------------------------------------------------------------
// bre_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/bre_pack.sv
// ----------------------------------------------------------------------------
// bre_pack: output byte packer
// Collects encoded bytes four to a word and holds the outgoing word in an
// output register. A full word is held back until the next byte or the end
// of the step, so the final word of a line can still be flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module bre_pack
  import bre_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pack_cmd_t          cmd_i,
  output logic                    put_ready_o,
  output logic                    out_free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [WORD_W-1:0]  out_word_o,
  output logic      [FILL_W-1:0]  out_bytes_o,
  output logic                    out_last_o
);

  localparam logic [FILL_W-1:0] FillFull = FILL_W'(WORD_W / BYTE_W);

  logic [WORD_W-1:0] res_q, res_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              step_bytes_q, step_bytes_d;
  logic              ov_q, ov_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [FILL_W-1:0] nbytes_q, nbytes_d;
  logic              last_q, last_d;
  logic              out_free;
  logic              push;

  assign out_free    = !ov_q || !out_stall_i;
  assign put_ready_o = (fill_q != FillFull) || out_free;
  assign out_free_o  = out_free;

  always_comb begin
    res_d        = res_q;
    fill_d       = fill_q;
    step_bytes_d = step_bytes_q;
    push         = 1'b0;
    word_d       = word_q;
    nbytes_d     = nbytes_q;
    last_d       = last_q;

    if (cmd_i.put && put_ready_o) begin
      step_bytes_d = 1'b1;
      if (fill_q == FillFull) begin
        push     = 1'b1;
        word_d   = res_q;
        nbytes_d = fill_q;
        last_d   = 1'b0;
        res_d    = WORD_W'(cmd_i.data);
        fill_d   = FILL_W'(1);
      end else begin
        res_d  = res_q | (WORD_W'(cmd_i.data) << {fill_q[1:0], 3'b000});
        fill_d = fill_q + FILL_W'(1);
      end
    end

    if (cmd_i.step_end && out_free) begin
      step_bytes_d = 1'b0;
      // A line end always flushes; otherwise a full word goes out, and a
      // partial one only when the step added nothing.
      if (cmd_i.line_last || (fill_q == FillFull) ||
          (!step_bytes_q && (fill_q != '0))) begin
        push     = 1'b1;
        word_d   = res_q;
        nbytes_d = fill_q;
        last_d   = cmd_i.line_last;
        res_d    = '0;
        fill_d   = '0;
      end
    end

    if (push) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q        <= '0;
      fill_q       <= '0;
      step_bytes_q <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      res_q        <= res_d;
      fill_q       <= fill_d;
      step_bytes_q <= step_bytes_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    nbytes_q <= nbytes_d;
    last_q   <= last_d;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = word_q;
  assign out_bytes_o = nbytes_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

FILE: rtl/bre_dp.sv
// ----------------------------------------------------------------------------
// bre_dp: encoder datapath
// Holds the two-byte lookahead, the open run, the pending literal memory and
// the output packer, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module bre_dp
  import bre_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_status_t              status_o,
  input  wire logic [BYTE_W-1:0]  in_byte_i,
  input  wire logic               in_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [WORD_W-1:0]  out_word_o,
  output logic      [FILL_W-1:0]  out_bytes_o,
  output logic                    out_last_o
);

  logic [BYTE_W-1:0] b_q;
  logic              last_q, last_d;
  logic [LA_W-1:0]   la_q, la_d;
  logic [1:0]        la_cnt_q, la_cnt_d;
  logic              in_run_q, in_run_d;
  logic [BYTE_W-1:0] rv_q, rv_d;
  logic [CNT_W-1:0]  rl_q, rl_d;
  logic [CNT_W-1:0]  lc_q, lc_d;
  logic [LIT_AW-1:0] idx_q, idx_d;

  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  logic              put_ready;
  logic              out_free;
  logic              put_fire;
  logic              lit_last;
  pack_cmd_t         pack_cmd;

  assign put_fire = (cmd_i.put != PUT_NONE) && put_ready;
  assign lit_last = (CNT_W'(idx_q) + CNT_W'(1)) == lc_q;

  always_comb begin
    last_d   = last_q;
    la_d     = la_q;
    la_cnt_d = la_cnt_q;
    in_run_d = in_run_q;
    rv_d     = rv_q;
    rl_d     = rl_q;
    lc_d     = lc_q;
    idx_d    = idx_q;
    ram_we   = 1'b0;

    if (cmd_i.accept) begin
      last_d = in_last_i;
    end

    unique case (cmd_i.op)
      OP_NONE: ;
      OP_RUN_INC: rl_d = rl_q + CNT_W'(1);
      OP_RUN_BREAK: begin
        la_d     = LA_W'(b_q);
        la_cnt_d = 2'd1;
      end
      OP_RUN_START: begin
        in_run_d = 1'b1;
        rv_d     = b_q;
        rl_d     = CNT_W'(MIN_RUN);
        la_d     = '0;
        la_cnt_d = 2'd0;
      end
      OP_LIT_SHIFT: begin
        ram_we   = 1'b1;
        lc_d     = lc_q + CNT_W'(1);
        la_d     = {b_q, la_q[LA_W-1:BYTE_W]};
        la_cnt_d = 2'd2;
      end
      OP_LA_APPEND: begin
        if (la_cnt_q == 2'd0) begin
          la_d[BYTE_W-1:0] = b_q;
        end else begin
          la_d[LA_W-1:BYTE_W] = b_q;
        end
        la_cnt_d = la_cnt_q + 2'd1;
      end
      OP_LAST_LIT: begin
        ram_we   = 1'b1;
        lc_d     = lc_q + CNT_W'(1);
        la_d     = la_q >> BYTE_W;
        la_cnt_d = la_cnt_q - 2'd1;
      end
      default: ;
    endcase

    pack_cmd.put       = cmd_i.put != PUT_NONE;
    pack_cmd.step_end  = cmd_i.step_end;
    pack_cmd.line_last = last_q;
    unique case (cmd_i.put)
      PUT_NONE:    pack_cmd.data = '0;
      PUT_RUN_HDR: pack_cmd.data = 8'd1 - BYTE_W'(rl_q);
      PUT_RUN_VAL: begin
        pack_cmd.data = rv_q;
        if (put_fire) begin
          in_run_d = 1'b0;
          rl_d     = '0;
          rv_d     = '0;
        end
      end
      PUT_LIT_HDR: pack_cmd.data = BYTE_W'(lc_q) - 8'd1;
      PUT_LIT_DATA: begin
        pack_cmd.data = ram_rdata;
        if (put_fire) begin
          if (lit_last) begin
            idx_d = '0;
            lc_d  = '0;
          end else begin
            idx_d = idx_q + LIT_AW'(1);
          end
        end
      end
      default: pack_cmd.data = '0;
    endcase

    // Back to the reset state once the line has been closed.
    if (cmd_i.step_end && out_free && last_q) begin
      last_d   = 1'b0;
      la_d     = '0;
      la_cnt_d = 2'd0;
      in_run_d = 1'b0;
      rv_d     = '0;
      rl_d     = '0;
      lc_d     = '0;
      idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      la_q     <= '0;
      la_cnt_q <= 2'd0;
      in_run_q <= 1'b0;
      rv_q     <= '0;
      rl_q     <= '0;
      lc_q     <= '0;
      idx_q    <= '0;
    end else begin
      last_q   <= last_d;
      la_q     <= la_d;
      la_cnt_q <= la_cnt_d;
      in_run_q <= in_run_d;
      rv_q     <= rv_d;
      rl_q     <= rl_d;
      lc_q     <= lc_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      b_q <= in_byte_i;
    end
  end

  // The read address follows the next index, so the data for the current
  // index is always waiting in the read register.
  bre_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_RECORD)
  ) u_lit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(lc_q[LIT_AW-1:0]),
    .wdata_i(la_q[BYTE_W-1:0]),
    .raddr_i(idx_d),
    .rdata_o(ram_rdata)
  );

  bre_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pack_cmd),
    .put_ready_o(put_ready),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .out_bytes_o(out_bytes_o),
    .out_last_o (out_last_o)
  );

  assign status_o.in_run        = in_run_q;
  assign status_o.run_match     = b_q == rv_q;
  assign status_o.la_full       = la_cnt_q == 2'd2;
  assign status_o.triple        = (la_q[BYTE_W-1:0] == la_q[LA_W-1:BYTE_W]) &&
                                  (la_q[LA_W-1:BYTE_W] == b_q);
  assign status_o.la_empty      = la_cnt_q == 2'd0;
  assign status_o.lit_empty     = lc_q == '0;
  assign status_o.lit_fill_next = lc_q == CNT_W'(MAX_RECORD - 1);
  assign status_o.run_full      = rl_q >= CNT_W'(MAX_RECORD);
  assign status_o.line_last     = last_q;
  assign status_o.put_ready     = put_ready;
  assign status_o.out_free      = out_free;
  assign status_o.lit_last      = lit_last;

endmodule

`default_nettype wire

FILE: rtl/bre_ctrl.sv
// ----------------------------------------------------------------------------
// bre_ctrl: encoder controller
// Sequences one input byte: the run or literal decision, run and literal
// records, the line-end drain and the closing of the step in the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module bre_ctrl
  import bre_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = 1'b0;
    cmd_o.op        = OP_NONE;
    cmd_o.put       = PUT_NONE;
    cmd_o.step_end  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.in_run) begin
          if (status_i.run_match) begin
            cmd_o.op = OP_RUN_INC;
            state_d  = ST_POST;
          end else begin
            cmd_o.op = OP_RUN_BREAK;
            state_d  = ST_RUN_HDR;
          end
        end else if (status_i.la_full) begin
          if (status_i.triple) begin
            // Pending literals go out ahead of the new run.
            cmd_o.op = OP_RUN_START;
            state_d  = status_i.lit_empty ? ST_POST : ST_LIT_HDR;
          end else begin
            cmd_o.op = OP_LIT_SHIFT;
            state_d  = status_i.lit_fill_next ? ST_LIT_HDR : ST_POST;
          end
        end else begin
          cmd_o.op = OP_LA_APPEND;
          state_d  = ST_POST;
        end
      end
      ST_POST: begin
        if (status_i.in_run && (status_i.line_last || status_i.run_full)) begin
          state_d = ST_RUN_HDR;
        end else if (status_i.line_last && !status_i.la_empty) begin
          cmd_o.op = OP_LAST_LIT;
          state_d  = status_i.lit_fill_next ? ST_LIT_HDR : ST_POST;
        end else if (status_i.line_last && !status_i.lit_empty) begin
          state_d = ST_LIT_HDR;
        end else begin
          state_d = ST_END;
        end
      end
      ST_RUN_HDR: begin
        cmd_o.put = PUT_RUN_HDR;
        if (status_i.put_ready) begin
          state_d = ST_RUN_VAL;
        end
      end
      ST_RUN_VAL: begin
        cmd_o.put = PUT_RUN_VAL;
        if (status_i.put_ready) begin
          state_d = ST_POST;
        end
      end
      ST_LIT_HDR: begin
        cmd_o.put = PUT_LIT_HDR;
        if (status_i.put_ready) begin
          state_d = ST_LIT_DATA;
        end
      end
      ST_LIT_DATA: begin
        cmd_o.put = PUT_LIT_DATA;
        if (status_i.put_ready && status_i.lit_last) begin
          state_d = ST_POST;
        end
      end
      ST_END: begin
        cmd_o.step_end = 1'b1;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

`default_nettype wire

FILE: rtl/byterun_line_encoder_core.sv
// ----------------------------------------------------------------------------
// byterun_line_encoder_core: byte-run line encoder
// Packs one line of raw bytes into run and literal records, four output
// bytes to a word.
// ----------------------------------------------------------------------------
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o | in_byte_i, in_last_i
//   out     | out_valid_o / out_stall_i | out_word_o, out_bytes_o, out_last_o
//
// A byte passes the accept, decide, settle and close steps, plus one put for
// every encoded byte it releases, set by the single-byte path into the packer.
// A record that is opened from the settle step returns to settle once written.
// At a line end each held-back byte is stored as a literal in its own settle
// step before the drain. A stalled output with a word still waiting holds the
// close of every step, and holds a byte into the packer only when it is full.
// Reset clears all control state; the literal memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module byterun_line_encoder_core
  import bre_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [BYTE_W-1:0]  in_byte_i,
  input  wire logic               in_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [WORD_W-1:0]  out_word_o,
  output logic      [FILL_W-1:0]  out_bytes_o,
  output logic                    out_last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bre_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  bre_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .out_bytes_o(out_bytes_o),
    .out_last_o (out_last_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the byte-run line encoder core
// Lines of raw bytes are fed through the input channel while a local model of
// the run/literal packing predicts every 32-bit output transfer; each output
// transfer is compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bre_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 300;
  localparam int MAX_WORDS_STEP = 33;
  localparam int TARGET_ITEMS   = 370;
  localparam int SIDE_IN        = 0;
  localparam int SIDE_OUT       = 1;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } raw_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [FILL_W-1:0] nbytes;
    logic              last;
  } packed_word_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [BYTE_W-1:0] in_byte_i   = '0;
  logic              in_last_i   = 1'b0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [WORD_W-1:0] out_word_o;
  logic [FILL_W-1:0] out_bytes_o;
  logic              out_last_o;

  byterun_line_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .out_bytes_o (out_bytes_o),
    .out_last_o  (out_last_o)
  );

  always #6 clk_i = ~clk_i;

  raw_item_t    raw_q[$];
  packed_word_t expected_words[$];

  int err_cnt       = 0;
  int bytes_sent    = 0;
  int lines_sent    = 0;
  int words_checked = 0;
  int total_items   = 0;
  int in_gap        = 0;
  int out_hold      = 0;
  int idle_cycles   = 0;
  int calm_left[2]  = '{0, 0};

  logic [BYTE_W-1:0] gen_prev1 = '0;
  logic [BYTE_W-1:0] gen_prev2 = '0;

  // Encoder model state.
  logic [BYTE_W-1:0] lit_mem[MAX_RECORD];
  int                lit_cnt;
  logic [LA_W-1:0]   la_bytes;
  int                la_cnt;
  logic              run_active;
  logic [BYTE_W-1:0] run_val;
  int                run_len;
  logic [WORD_W-1:0] pk_residue;
  int                pk_fill;
  int                step_bytes;
  int                step_words;

  task automatic clear_model();
    lit_cnt    = 0;
    la_bytes   = '0;
    la_cnt     = 0;
    run_active = 1'b0;
    run_val    = '0;
    run_len    = 0;
    pk_residue = '0;
    pk_fill    = 0;
  endtask

  task automatic push_word(logic [WORD_W-1:0] w, int n, logic last);
    packed_word_t pw;
    if (step_words >= MAX_WORDS_STEP) return;
    pw.word   = w;
    pw.nbytes = FILL_W'(n);
    pw.last   = last;
    expected_words.push_back(pw);
    step_words++;
  endtask

  task automatic put_out_byte(logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] w;
    w = pk_residue | (WORD_W'(b) << (8 * pk_fill));
    step_bytes++;
    pk_fill++;
    if (pk_fill >= 4) begin
      push_word(w, 4, 1'b0);
      pk_residue = '0;
      pk_fill    = 0;
    end else begin
      pk_residue = w;
    end
  endtask

  task automatic flush_literals();
    if (lit_cnt == 0) return;
    put_out_byte(BYTE_W'(lit_cnt - 1));
    for (int i = 0; i < lit_cnt; i++) put_out_byte(lit_mem[i]);
    lit_cnt = 0;
  endtask

  task automatic add_literal(logic [BYTE_W-1:0] b);
    if (lit_cnt < MAX_RECORD) begin
      lit_mem[lit_cnt] = b;
      lit_cnt++;
    end
    if (lit_cnt >= MAX_RECORD) flush_literals();
  endtask

  task automatic emit_run();
    put_out_byte(BYTE_W'(1 - run_len));
    put_out_byte(run_val);
    run_active = 1'b0;
    run_len    = 0;
    run_val    = '0;
  endtask

  // Predicts the output words caused by one accepted input byte.
  task automatic encode_byte(logic [BYTE_W-1:0] b, logic last);
    logic [BYTE_W-1:0] b0, b1;
    packed_word_t      pw;
    step_bytes = 0;
    step_words = 0;
    if (run_active) begin
      if (b == run_val) begin
        run_len++;
        if (run_len >= MAX_RECORD) emit_run();
      end else begin
        emit_run();
        la_bytes = LA_W'(b);
        la_cnt   = 1;
      end
    end else if (la_cnt >= 2) begin
      b0 = la_bytes[7:0];
      b1 = la_bytes[15:8];
      if (b0 == b1 && b1 == b) begin
        flush_literals();
        run_active = 1'b1;
        run_val    = b;
        run_len    = MIN_RUN;
        la_bytes   = '0;
        la_cnt     = 0;
        if (run_len >= MAX_RECORD) emit_run();
      end else begin
        add_literal(b0);
        la_bytes = {b, b1};
        la_cnt   = 2;
      end
    end else begin
      la_bytes = la_bytes | (LA_W'(b) << (8 * la_cnt));
      la_cnt++;
    end

    if (last) begin
      if (run_active) emit_run();
      for (int i = 0; i < la_cnt && i < 2; i++) add_literal(la_bytes[8*i +: 8]);
      flush_literals();
      if (pk_fill > 0) begin
        push_word(pk_residue, pk_fill, 1'b1);
      end else if (step_words > 0) begin
        // The line closed on a full word: mark that word as the final one.
        pw = expected_words.pop_back();
        pw.last = 1'b1;
        expected_words.push_back(pw);
      end
      clear_model();
    end else if (step_bytes == 0 && pk_fill > 0) begin
      // Nothing new was encoded, so the packed residue leaves as a partial word.
      push_word(pk_residue, pk_fill, 1'b0);
      pk_residue = '0;
      pk_fill    = 0;
    end
  endtask

  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 19);
    return $urandom_range(0, 2);
  endfunction

  task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (err_cnt < MAX_PRINTED)
      $display("tb: mismatch at %0t ns: %s, got %h, want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // Stimulus builders.
  task automatic push_raw(logic [BYTE_W-1:0] b);
    raw_item_t it;
    it.b    = b;
    it.last = 1'b0;
    raw_q.push_back(it);
    gen_prev2 = gen_prev1;
    gen_prev1 = b;
  endtask

  task automatic end_line();
    raw_item_t it;
    it = raw_q.pop_back();
    it.last = 1'b1;
    raw_q.push_back(it);
  endtask

  task automatic gen_run(logic [BYTE_W-1:0] v, int n);
    repeat (n) push_raw(v);
  endtask

  // Mostly distinct bytes with some pairs, never three equal in a row.
  task automatic gen_literals(int n);
    logic [BYTE_W-1:0] b;
    repeat (n) begin
      b = ($urandom_range(0, 3) == 0) ? gen_prev1 : BYTE_W'($urandom_range(0, 255));
      if (b == gen_prev1 && b == gen_prev2) b = b ^ 8'h01;
      push_raw(b);
    end
  endtask

  task automatic gen_noise(int n);
    repeat (n) push_raw($urandom_range(0, 1) ? 8'hFF : 8'h00);
  endtask

  task automatic random_line();
    int nseg;
    nseg = $urandom_range(1, 5);
    repeat (nseg) begin
      case ($urandom_range(0, 3))
        0: gen_run(BYTE_W'($urandom_range(0, 255)), $urandom_range(2, 12));
        1: gen_literals($urandom_range(1, 12));
        2: gen_noise($urandom_range(1, 10));
        default: begin
          gen_run(BYTE_W'($urandom_range(0, 255)), $urandom_range(1, 4));
          gen_literals($urandom_range(1, 3));
        end
      endcase
    end
    end_line();
  endtask

  // Input driver.
  always @(posedge clk_i or negedge rst_ni) begin
    raw_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= '0;
      in_last_i  <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encode_byte(in_byte_i, in_last_i);
        bytes_sent++;
        if (in_last_i) lines_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (raw_q.size() > 0) begin
          nxt = raw_q.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i  <= nxt.b;
          in_last_i  <= nxt.last;
          in_gap     <= draw_wait(SIDE_IN);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    packed_word_t want;
    int           hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    <= 0;
    end else begin
      hold = out_hold;
      if (out_valid_o && !out_stall_i) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          report("word with nothing expected", out_word_o, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_o !== want.word) report("out_word", out_word_o, want.word);
          if (out_bytes_o !== want.nbytes)
            report("out_bytes", WORD_W'(out_bytes_o), WORD_W'(want.nbytes));
          if (out_last_o !== want.last)
            report("out_last", WORD_W'(out_last_o), WORD_W'(want.last));
        end
        hold = draw_wait(SIDE_OUT);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold    <= hold - 1;
      end else begin
        out_stall_i <= 1'b0;
        out_hold    <= 0;
      end
    end
  end

  // Ends the run when neither channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired, %0d words still expected", expected_words.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_model();

    // Directed lines: single byte, extreme values, a run closing the line,
    // held-back pairs, a run broken by a different byte.
    push_raw(8'h00); end_line();
    push_raw(8'hFF); push_raw(8'h00); end_line();
    gen_run(8'hAA, 3); end_line();
    push_raw(8'h01); gen_run(8'h02, 4); push_raw(8'h03); end_line();
    gen_run(8'hFF, 2); end_line();
    push_raw(8'h80); push_raw(8'h7F); push_raw(8'h80); push_raw(8'h7F);
    push_raw(8'h80); end_line();
    gen_run(8'h00, 4); push_raw(8'h11); end_line();

    // A run at or past the record limit, then a literal block at or past the limit.
    gen_literals(3);
    gen_run(BYTE_W'($urandom_range(0, 255)), $urandom_range(MAX_RECORD, MAX_RECORD + 8));
    gen_literals(2);
    end_line();
    gen_literals($urandom_range(MAX_RECORD, MAX_RECORD + 6));
    gen_run(BYTE_W'($urandom_range(0, 255)), MIN_RUN);
    end_line();

    while (raw_q.size() < TARGET_ITEMS) random_line();
    total_items = raw_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_sent < total_items) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_words.size() != 0)
      report("words never produced", WORD_W'(expected_words.size()), '0);

    $display("tb: %0d bytes in %0d lines encoded, %0d packed words compared",
             bytes_sent, lines_sent, words_checked);
    $display("tb: runs and literal blocks beyond %0d bytes included, %0d mismatches",
             MAX_RECORD, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bre_pkg.sv
rtl/bre_ram.sv
rtl/bre_pack.sv
rtl/bre_dp.sv
rtl/bre_ctrl.sv
rtl/byterun_line_encoder_core.sv
tb/tb.sv
